@@ rtl/core/sed_pkg.sv @@
// Shared types, constants and helper functions for the Sobel edge detector core.
// Used by sed_front, sed_queue, sed_back and sobel_edge_detector_core.
`default_nettype none
package sed_pkg;

  localparam int unsigned PIX_W         = 8;
  localparam int unsigned GRAD_W        = 11;
  localparam int unsigned MAG_W         = 11;
  localparam int unsigned ANG_W         = 9;
  localparam int unsigned CFG_W         = 11;
  localparam int unsigned SQ_W          = 21;
  localparam int unsigned SQ_STEPS      = (SQ_W + 1) / 2;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned DEF_MAX_WIDTH = 1024;
  localparam int unsigned ANG_STEPS     = 45;
  localparam int unsigned ANG_IDX_W     = 6;
  localparam int unsigned ABS_W         = 10;

  localparam logic [CFG_W-1:0]     WIDTH_RESET  = 11'd1024;
  localparam logic [PIX_W-1:0]     EDGE_ON      = 8'd255;
  localparam logic [PIX_W-1:0]     EDGE_OFF     = 8'd0;
  localparam logic [ANG_IDX_W:0]   ANG_DIAG     = 7'd45;
  localparam logic [ANG_IDX_W:0]   ANG_RIGHT    = 7'd90;
  localparam logic [ANG_W-1:0]     ANG_STRAIGHT = 9'd180;

  typedef enum logic {
    CFG_EDGE_THRESHOLD = 1'b0,
    CFG_IMAGE_WIDTH    = 1'b1
  } cfg_index_e;

  // One gradient pair travelling from the front to the back.
  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic                     last;
  } sed_grad_t;

  // 3x3 window, indexed [row][column]; row 0 is the earliest row.
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  typedef logic [32:0] trig_tab_t [ANG_STEPS];

  // Grey value from Q0.16 weights, truncated.
  function automatic logic [PIX_W-1:0] grey_of(input logic [PIX_W-1:0] r,
                                                input logic [PIX_W-1:0] g,
                                                input logic [PIX_W-1:0] b);
    logic [23:0] sum;
    sum = 24'(19595) * 24'(r) + 24'(38470) * 24'(g) + 24'(7471) * 24'(b);
    return sum[23:16];
  endfunction

  // Right tap column minus left one, weighted 1,2,1.
  function automatic logic signed [GRAD_W-1:0] sobel_gx(input win_t w);
    logic [GRAD_W-1:0] pos;
    logic [GRAD_W-1:0] neg;
    pos = GRAD_W'(w[0][2]) + {2'b0, w[1][2], 1'b0} + GRAD_W'(w[2][2]);
    neg = GRAD_W'(w[0][0]) + {2'b0, w[1][0], 1'b0} + GRAD_W'(w[2][0]);
    return $signed(pos - neg);
  endfunction

  // Lower tap row minus upper one, weighted 1,2,1.
  function automatic logic signed [GRAD_W-1:0] sobel_gy(input win_t w);
    logic [GRAD_W-1:0] pos;
    logic [GRAD_W-1:0] neg;
    pos = GRAD_W'(w[2][0]) + {2'b0, w[2][1], 1'b0} + GRAD_W'(w[2][2]);
    neg = GRAD_W'(w[0][0]) + {2'b0, w[0][1], 1'b0} + GRAD_W'(w[0][2]);
    return $signed(pos - neg);
  endfunction

  // Unsigned 64-bit quotient by shift and subtract, for building the tables.
  function automatic logic [63:0] quo64(input logic [63:0] num,
                                        input logic [63:0] dvs);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, dvs}) begin
        rem    = rem - {1'b0, dvs};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sine or cosine of whole degrees in Q32, Taylor series with truncated
  // products. Evaluated at elaboration only.
  function automatic trig_tab_t build_trig(input logic cosine);
    trig_tab_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] acc;
    logic [63:0] den;
    for (int k = 0; k < ANG_STEPS; k++) begin
      x  = quo64(64'(k) * 64'd13493037705, 64'd180);
      x2 = (x * x) >> 32;
      t   = cosine ? 64'd4294967296 : x;
      acc = t;
      for (int n = 1; n <= 12; n++) begin
        den = cosine ? 64'((2 * n - 1) * (2 * n)) : 64'((2 * n) * (2 * n + 1));
        t = quo64((t * x2) >> 32, den);
        if ((n & 1) == 1) acc = acc - t;
        else acc = acc + t;
      end
      tab[k] = acc[32:0];
    end
    return tab;
  endfunction

  localparam trig_tab_t SIN_TAB = build_trig(1'b0);
  localparam trig_tab_t COS_TAB = build_trig(1'b1);

endpackage
`default_nettype wire

@@ rtl/core/sed_front.sv @@
// Front part: accepts pixel beats, converts to grey, keeps the two line stores
// and the 3x3 window, and pushes gradient pairs into the queue. Uses sed_pkg.
`default_nettype none
module sed_front #(
  parameter int unsigned MAX_WIDTH = sed_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  output logic                              ready_o,
  input  wire logic [sed_pkg::PIX_W-1:0]    red_i,
  input  wire logic [sed_pkg::PIX_W-1:0]    green_i,
  input  wire logic [sed_pkg::PIX_W-1:0]    blue_i,
  input  wire logic                         start_of_frame_i,
  input  wire logic                         pad_row_i,
  input  wire logic [sed_pkg::CFG_W-1:0]    image_width_i,
  input  wire logic                         space_i,
  output logic                              push_o,
  output sed_pkg::sed_grad_t                push_data_o
);
  import sed_pkg::*;

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned LW = ((CW + 1 > CFG_W) ? CW + 1 : CFG_W) + 1;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_READ = 3'b010,
    F_LAST = 3'b100
  } front_state_e;

  front_state_e   state_q, state_d;
  logic [CW-1:0]  col_q, col_d;
  logic [1:0]     row_q, row_d;
  logic [CW-1:0]  c_q;
  logic [1:0]     rowe_q;
  logic [PIX_W-1:0] grey_q;
  logic           pad_q;
  logic           last_q;
  win_t           win_q, win_d;

  logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
  logic [PIX_W-1:0] up_rd_q, mid_rd_q;

  logic           accept;
  logic [CW-1:0]  c_acc;
  logic [1:0]     row_acc;
  logic [LW-1:0]  w_ext, w_eff;
  logic           last_acc;
  logic [PIX_W-1:0] mid, top, bot;
  win_t           win_read, win_last;
  logic           mem_we;

  // Beat acceptance and the effective column and row of the new pixel.
  assign ready_o = (state_q == F_IDLE) && space_i;
  assign accept  = valid_i && ready_o;
  assign c_acc   = start_of_frame_i ? '0 : col_q;
  assign row_acc = start_of_frame_i ? 2'd0 : row_q;

  // Row width clamped to 1..MAX_WIDTH.
  always_comb begin
    w_ext = LW'(image_width_i);
    if (w_ext == '0) w_eff = LW'(1);
    else if (w_ext > LW'(MAX_WIDTH)) w_eff = LW'(MAX_WIDTH);
    else w_eff = w_ext;
  end
  assign last_acc = (LW'(c_acc) + LW'(1)) >= w_eff;

  // Tap column entering the window.
  assign mid = mid_rd_q;
  assign top = (rowe_q >= 2'd2) ? up_rd_q : mid_rd_q;
  assign bot = pad_q ? mid_rd_q : grey_q;

  // Window after the line store read, and after the right border copy.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (c_q == '0) begin
        win_read[r][0] = (r == 0) ? top : ((r == 1) ? mid : bot);
        win_read[r][1] = win_read[r][0];
        win_read[r][2] = win_read[r][0];
      end else begin
        win_read[r][0] = win_q[r][1];
        win_read[r][1] = win_q[r][2];
        win_read[r][2] = (r == 0) ? top : ((r == 1) ? mid : bot);
      end
      if (c_q != '0) begin
        win_last[r][0] = win_q[r][1];
        win_last[r][1] = win_q[r][2];
        win_last[r][2] = win_q[r][2];
      end else begin
        win_last[r] = win_q[r];
      end
    end
  end

  // Sequencer: read, then an extra step for the last column of a row.
  always_comb begin
    state_d          = state_q;
    col_d            = col_q;
    row_d            = row_q;
    win_d            = win_q;
    push_o           = 1'b0;
    push_data_o.gx   = sobel_gx(win_read);
    push_data_o.gy   = sobel_gy(win_read);
    push_data_o.last = 1'b0;
    mem_we           = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (accept) state_d = F_READ;
      end
      F_READ: begin
        win_d  = win_read;
        mem_we = 1'b1;
        push_o = (c_q != '0) && (rowe_q != 2'd0);
        if (last_q) begin
          col_d   = '0;
          row_d   = (rowe_q == 2'd2) ? 2'd2 : rowe_q + 2'd1;
          state_d = F_LAST;
        end else begin
          col_d   = c_q + CW'(1);
          row_d   = rowe_q;
          state_d = F_IDLE;
        end
      end
      F_LAST: begin
        win_d            = win_last;
        push_o           = (rowe_q != 2'd0);
        push_data_o.gx   = sobel_gx(win_last);
        push_data_o.gy   = sobel_gy(win_last);
        push_data_o.last = 1'b1;
        state_d          = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  // Control and window registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      col_q   <= '0;
      row_q   <= 2'd0;
      win_q   <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      win_q   <= win_d;
    end
  end

  // Pixel held while it is worked on.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      c_q    <= c_acc;
      rowe_q <= row_acc;
      grey_q <= grey_of(red_i, green_i, blue_i);
      pad_q  <= pad_row_i;
      last_q <= last_acc;
    end
  end

  // Line stores: one write and one registered read per cycle each.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      upper_mem[c_q]  <= mid;
      middle_mem[c_q] <= bot;
    end
    if (accept) begin
      up_rd_q  <= upper_mem[c_acc];
      mid_rd_q <= middle_mem[c_acc];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/sed_queue.sv @@
// Short queue of gradient pairs between the front and back parts.
// Uses sed_pkg.
`default_nettype none
module sed_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  sed_pkg::sed_grad_t       push_data_i,
  input  wire logic                pop_i,
  output sed_pkg::sed_grad_t       pop_data_o,
  output logic                     valid_o,
  output logic                     space_o
);
  import sed_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  sed_grad_t     mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   count_q;

  // Room for the two beats one pixel can produce.
  assign valid_o    = (count_q != '0);
  assign space_o    = (count_q <= (PW+1)'(QUEUE_DEPTH - 2));
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + PW'(1);
      if (pop_i) rd_q <= rd_q + PW'(1);
      count_q <= count_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  // The front only pushes when there is room.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < (PW+1)'(QUEUE_DEPTH)))
    else $error("queue push while full");

  // The back only pops a held entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue pop while empty");

  // Fill level follows the pointers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_q == rd_q))
    else $error("queue pointers disagree with fill level");

endmodule
`default_nettype wire

@@ rtl/core/sed_back.sv @@
// Back part: square root of the gradient energy and angle search over the
// sine/cosine tables, then the output register. Uses sed_pkg.
`default_nettype none
module sed_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         q_valid_i,
  input  sed_pkg::sed_grad_t                q_data_i,
  output logic                              pop_o,
  input  wire logic [sed_pkg::CFG_W-1:0]    threshold_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [sed_pkg::MAG_W-1:0]         magnitude_o,
  output logic [sed_pkg::PIX_W-1:0]         edge_value_o,
  output logic signed [sed_pkg::ANG_W-1:0]  angle_degrees_o,
  output logic                              last_in_row_o
);
  import sed_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_RUN  = 3'b010,
    B_DONE = 3'b100
  } back_state_e;

  back_state_e state_q, state_d;
  logic [SQ_W-1:0]      rem_q;
  logic [SQ_W:0]        res_q;
  logic [3:0]           cnt_q;
  logic [ANG_IDX_W-1:0] lo_q, hi_q;
  logic [ABS_W-1:0]     r_q, s_q;
  logic gx_zero_q, gx_neg_q, gy_zero_q, gy_neg_q, q_le_p_q, eq_q, last_q;

  logic                 out_valid_q;
  logic [MAG_W-1:0]     mag_q;
  logic [PIX_W-1:0]     edge_q;
  logic signed [ANG_W-1:0] ang_q;
  logic                 olast_q;

  logic [GRAD_W-1:0]    p_abs, q_abs;
  logic signed [2*GRAD_W-1:0] gx2, gy2;
  logic [2*GRAD_W-1:0]  energy;
  logic [SQ_W:0]        bit_v, trial;
  logic [ANG_IDX_W:0]   mid_sum;
  logic [ANG_IDX_W-1:0] mid;
  logic [42:0]          lhs, rhs;
  logic                 load;
  logic [ANG_IDX_W:0]   fb, cb, fl, ce;
  logic                 exact;
  logic signed [ANG_W-1:0] ang;
  logic [MAG_W-1:0]     mag;

  // Operands for a popped pair.
  assign p_abs  = q_data_i.gx[GRAD_W-1] ? GRAD_W'(-q_data_i.gx) : q_data_i.gx;
  assign q_abs  = q_data_i.gy[GRAD_W-1] ? GRAD_W'(-q_data_i.gy) : q_data_i.gy;
  assign gx2    = q_data_i.gx * q_data_i.gx;
  assign gy2    = q_data_i.gy * q_data_i.gy;
  assign energy = gx2 + gy2;

  // One square root digit per cycle.
  assign bit_v = (SQ_W+1)'(1) << {cnt_q - 4'd1, 1'b0};
  assign trial = res_q + bit_v;

  // One binary search step over the degree tables per cycle.
  assign mid_sum = ({1'b0, lo_q} + {1'b0, hi_q} + (ANG_IDX_W+1)'(1)) >> 1;
  assign mid     = mid_sum[ANG_IDX_W-1:0];
  assign lhs     = 43'(s_q) * 43'(SIN_TAB[mid]);
  assign rhs     = 43'(r_q) * 43'(COS_TAB[mid]);

  // Angle from the found whole degree and the signs.
  always_comb begin
    fb    = eq_q ? ANG_DIAG : (ANG_IDX_W+1)'(lo_q);
    exact = eq_q || (r_q == '0);
    cb    = exact ? fb : fb + (ANG_IDX_W+1)'(1);
    if (q_le_p_q) begin
      fl = fb;
      ce = cb;
    end else begin
      fl = ANG_RIGHT - cb;
      ce = ANG_RIGHT - fb;
    end
    if (gx_zero_q) ang = ANG_W'(ANG_RIGHT);
    else if (!gx_neg_q) ang = gy_neg_q ? -ANG_W'(fl) : ANG_W'(fl);
    else if (gy_zero_q) ang = ANG_STRAIGHT;
    else if (!gy_neg_q) ang = ANG_STRAIGHT - ANG_W'(ce);
    else ang = -(ANG_STRAIGHT - ANG_W'(ce));
  end
  assign mag = res_q[MAG_W-1:0];

  // Sequencer.
  assign load = (state_q == B_DONE) && (!out_valid_q || out_ready_i);
  assign pop_o = (state_q == B_IDLE) && q_valid_i;
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: if (q_valid_i) state_d = B_RUN;
      B_RUN:  if ((cnt_q == 4'd0) && (lo_q == hi_q)) state_d = B_DONE;
      B_DONE: if (load) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Iteration registers.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rem_q     <= energy[SQ_W-1:0];
      res_q     <= '0;
      cnt_q     <= 4'(SQ_STEPS);
      lo_q      <= '0;
      hi_q      <= ANG_IDX_W'(ANG_STEPS - 1);
      r_q       <= (p_abs < q_abs) ? p_abs[ABS_W-1:0] : q_abs[ABS_W-1:0];
      s_q       <= (p_abs < q_abs) ? q_abs[ABS_W-1:0] : p_abs[ABS_W-1:0];
      eq_q      <= (p_abs == q_abs);
      q_le_p_q  <= (q_abs <= p_abs);
      gx_zero_q <= (q_data_i.gx == '0);
      gx_neg_q  <= q_data_i.gx[GRAD_W-1];
      gy_zero_q <= (q_data_i.gy == '0);
      gy_neg_q  <= q_data_i.gy[GRAD_W-1];
      last_q    <= q_data_i.last;
    end else if (state_q == B_RUN) begin
      if (cnt_q != 4'd0) begin
        cnt_q <= cnt_q - 4'd1;
        if ({1'b0, rem_q} >= trial) begin
          rem_q <= rem_q - trial[SQ_W-1:0];
          res_q <= (res_q >> 1) + bit_v;
        end else begin
          res_q <= res_q >> 1;
        end
      end
      if (lo_q != hi_q) begin
        if (lhs <= rhs) lo_q <= mid;
        else hi_q <= mid - ANG_IDX_W'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      mag_q   <= mag;
      edge_q  <= (MAG_W'(threshold_i) < mag) ? EDGE_ON : EDGE_OFF;
      ang_q   <= ang;
      olast_q <= last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign magnitude_o     = mag_q;
  assign edge_value_o    = edge_q;
  assign angle_degrees_o = ang_q;
  assign last_in_row_o   = olast_q;

  // A result is never loaded over one still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(mag_q) && $stable(ang_q))
    else $error("waiting result overwritten");

  // Search bounds stay ordered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_RUN) |-> (lo_q <= hi_q))
    else $error("angle search bounds crossed");

  // Done only after all square root digits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DONE) |-> (cnt_q == 4'd0))
    else $error("result finished early");

endmodule
`default_nettype wire

@@ rtl/core/sobel_edge_detector_core.sv @@
// Sobel 3x3 edge detector: a raster-order RGB stream in, one magnitude, edge
// value and angle per pixel out, one row and one column late, each pixel
// turned to grey and framed in a 3x3 window with replicated borders. A row of
// pad beats flushes the last row. Each pixel is accepted in the front, then
// the line stores are read and the window updated, with an extra step on the
// last column of a row. Each result in the back is taken from the queue,
// then the 11-digit square root runs alongside a 6-step binary search of the
// degree tables, and then the output register is loaded; the back takes no
// new pair from the queue until its last result is loaded. A result
// that waits at the output holds the back, and the front then stalls once the
// queue has no room for two more pairs. The line stores need no clearing
// after reset. Uses sed_pkg, sed_front, sed_queue and sed_back.
`default_nettype none
module sobel_edge_detector_core #(
  parameter int unsigned MAX_WIDTH = sed_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [23:0]                s_axis_tdata,  // red, green, blue
  input  wire logic [1:0]                 s_axis_tuser,  // start_of_frame, pad_row
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [31:0]                     m_axis_tdata,  // magnitude, edge_value,
                                                         // angle_degrees, zero
  output logic                            m_axis_tlast,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic                       cfg_index_i,
  input  wire logic [sed_pkg::CFG_W-1:0]  cfg_data_i
);
  import sed_pkg::*;

  logic [CFG_W-1:0] threshold_q, width_q;
  logic             push, pop, q_valid, q_space;
  sed_grad_t        push_data, pop_data;
  logic [MAG_W-1:0] mag;
  logic [PIX_W-1:0] edge_v;
  logic signed [ANG_W-1:0] ang;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= '0;
      width_q     <= WIDTH_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_EDGE_THRESHOLD: threshold_q <= cfg_data_i;
        CFG_IMAGE_WIDTH:    width_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sed_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i,
    .rst_ni,
    .valid_i          (s_axis_tvalid),
    .ready_o          (s_axis_tready),
    .red_i            (s_axis_tdata[7:0]),
    .green_i          (s_axis_tdata[15:8]),
    .blue_i           (s_axis_tdata[23:16]),
    .start_of_frame_i (s_axis_tuser[0]),
    .pad_row_i        (s_axis_tuser[1]),
    .image_width_i    (width_q),
    .space_i          (q_space),
    .push_o           (push),
    .push_data_o      (push_data)
  );

  sed_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .valid_o     (q_valid),
    .space_o     (q_space)
  );

  sed_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i       (q_valid),
    .q_data_i        (pop_data),
    .pop_o           (pop),
    .threshold_i     (threshold_q),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .magnitude_o     (mag),
    .edge_value_o    (edge_v),
    .angle_degrees_o (ang),
    .last_in_row_o   (m_axis_tlast)
  );

  // Result beat packing.
  assign m_axis_tdata = {4'b0, ang, edge_v, mag};

endmodule
`default_nettype wire

@@ tb/sobel_edge_detector_core_test.sv @@
// Self-checking testbench for sobel_edge_detector_core: a directed table, then
// random frames, checked beat by beat against a behavioural predictor.
// Depends on sed_pkg and the RTL of the core only.
`timescale 1ns / 100ps
`default_nettype none
module sobel_edge_detector_core_test;
  import sed_pkg::*;

  typedef struct packed {
    logic [10:0]       mag;
    logic [7:0]        edge_v;
    logic signed [8:0] ang;
    logic              last;
  } pix_result_t;

  typedef enum logic { ROW_PIX, ROW_CFG } row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [7:0]  r, g, b;
    logic        sof, pad;
    cfg_index_e  idx;
    logic [10:0] data;
    logic        typed;
    pix_result_t res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // red, green, blue
  logic [1:0] s_axis_tuser = '0;    // start_of_frame, pad_row
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // magnitude, edge_value, angle_degrees, zero
  logic m_axis_tlast;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  cfg_index_e cfg_index_i = CFG_EDGE_THRESHOLD;
  logic [CFG_W-1:0] cfg_data_i = '0;

  sobel_edge_detector_core u_top (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state.
  logic [10:0] thr_q, width_q;
  logic [7:0] upper_q [1024];
  logic [7:0] middle_q [1024];
  bit mid_known [1024];
  logic [7:0] tap [9];
  int unsigned col_q, row_q;
  longint unsigned sin_t [45], cos_t [45];
  pix_result_t expected_q [$];

  int errors = 0;
  int items = 0;
  int snd_pct = 0;
  int rcv_pct = 0;
  stim_row_t stim_tab [$];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Q32 sine and cosine tables of whole degrees, truncated Taylor series.
  task automatic build_trig_tables();
    longint unsigned x, x2, t, s, c;
    for (int k = 0; k < 45; k++) begin
      x = longint'(k) * 64'd13493037705 / 64'd180;
      x2 = (x * x) >> 32;
      t = x;
      s = x;
      for (int n = 1; n <= 12; n++) begin
        t = ((t * x2) >> 32) / longint'((2 * n) * (2 * n + 1));
        if (n % 2) s -= t; else s += t;
      end
      t = 64'd4294967296;
      c = t;
      for (int n = 1; n <= 12; n++) begin
        t = ((t * x2) >> 32) / longint'((2 * n - 1) * (2 * n));
        if (n % 2) c -= t; else c += t;
      end
      sin_t[k] = s;
      cos_t[k] = c;
    end
  endtask

  function automatic int unsigned int_sqrt(input int unsigned v);
    int unsigned res, bitv;
    res = 0;
    bitv = 1 << 30;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic int angle_deg(input int gx, input int gy);
    longint unsigned p, q, rr, ss;
    int fb, cb, fl, ce;
    bit exact;
    if (gx == 0) return 90;
    p = (gx < 0) ? -gx : gx;
    q = (gy < 0) ? -gy : gy;
    rr = (p < q) ? p : q;
    ss = (p < q) ? q : p;
    fb = 0;
    if (rr == ss) begin
      fb = 45;
      exact = 1'b1;
    end else begin
      for (int k = 1; k < 45; k++)
        if (ss * sin_t[k] <= rr * cos_t[k]) fb = k;
      exact = (rr == 0);
    end
    cb = exact ? fb : fb + 1;
    if (q <= p) begin
      fl = fb;
      ce = cb;
    end else begin
      fl = 90 - cb;
      ce = 90 - fb;
    end
    if (gx > 0) return (gy < 0) ? -fl : fl;
    if (gy == 0) return 180;
    return (gy > 0) ? 180 - ce : -(180 - ce);
  endfunction

  task automatic shift_col(input logic [7:0] t0, input logic [7:0] t1, input logic [7:0] t2);
    for (int i = 0; i < 3; i++) begin
      tap[i * 3] = tap[i * 3 + 1];
      tap[i * 3 + 1] = tap[i * 3 + 2];
    end
    tap[2] = t0;
    tap[5] = t1;
    tap[8] = t2;
  endtask

  task automatic push_result(input logic lst);
    int gx, gy;
    pix_result_t e;
    gx = (tap[2] + 2 * tap[5] + tap[8]) - (tap[0] + 2 * tap[3] + tap[6]);
    gy = (tap[6] + 2 * tap[7] + tap[8]) - (tap[0] + 2 * tap[1] + tap[2]);
    e.mag = 11'(int_sqrt(gx * gx + gy * gy));
    e.edge_v = (e.mag > thr_q) ? EDGE_ON : EDGE_OFF;
    e.ang = 9'(angle_deg(gx, gy));
    e.last = lst;
    expected_q.push_back(e);
  endtask

  // Works out the results caused by one accepted pixel beat.
  task automatic predict_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                               input logic sof, input logic pad);
    int unsigned w, c;
    logic [23:0] sum;
    logic [7:0] v, top, mid, bot;
    logic lst;
    w = (width_q == 0) ? 1 : ((width_q > 1024) ? 1024 : width_q);
    if (sof) begin
      col_q = 0;
      row_q = 0;
    end
    c = (col_q >= 1024) ? 0 : col_q;
    sum = 24'd19595 * r + 24'd38470 * g + 24'd7471 * b;
    v = sum[23:16];
    mid = middle_q[c];
    top = (row_q >= 2) ? upper_q[c] : mid;
    bot = pad ? mid : v;
    lst = (c + 1 >= w);
    if (c == 0) begin
      for (int i = 0; i < 3; i++) begin
        tap[i] = top;
        tap[3 + i] = mid;
        tap[6 + i] = bot;
      end
    end else begin
      shift_col(top, mid, bot);
      if (row_q >= 1) push_result(1'b0);
    end
    if (lst) begin
      if (c != 0) shift_col(tap[2], tap[5], tap[8]);
      if (row_q >= 1) push_result(1'b1);
    end
    upper_q[c] = mid;
    middle_q[c] = bot;
    if (!pad) mid_known[c] = 1'b1;
    if (lst) begin
      col_q = 0;
      if (row_q < 2047) row_q++;
    end else begin
      col_q = c + 1;
    end
  endtask

  // Drives one pixel beat, with optional idle cycles ahead of it.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic sof, input logic pad);
    int unsigned c;
    // A pad in row 0 would copy a line store entry that was never written.
    c = sof ? 0 : col_q;
    if (pad && (sof || row_q == 0) && !mid_known[c]) pad = 1'b0;
    if ($urandom_range(0, 99) < snd_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {b, g, r};
    s_axis_tuser <= {pad, sof};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_pixel(r, g, b, sof, pad);
    items++;
  endtask

  task automatic write_reg(input cfg_index_e idx, input logic [10:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_EDGE_THRESHOLD) thr_q = data; else width_q = data;
  endtask

  // Lets every expected beat arrive, then allows for back-end latency.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  function automatic stim_row_t pix_row(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b, input logic sof,
                                        input logic pad, input logic typed,
                                        input logic [10:0] mag, input logic [7:0] ev,
                                        input int ang);
    stim_row_t s;
    s.kind = ROW_PIX;
    s.r = r; s.g = g; s.b = b; s.sof = sof; s.pad = pad;
    s.idx = CFG_EDGE_THRESHOLD; s.data = '0;
    s.typed = typed;
    s.res = '{mag, ev, 9'(ang), 1'b1};
    return s;
  endfunction

  function automatic stim_row_t cfg_row(input cfg_index_e idx, input logic [10:0] data);
    stim_row_t s;
    s = pix_row(0, 0, 0, 0, 0, 0, 0, 0, 0);
    s.kind = ROW_CFG;
    s.idx = idx;
    s.data = data;
    return s;
  endfunction

  function automatic logic [7:0] rand_chan();
    return ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 8'd255 : 8'd0)
                                       : 8'($urandom_range(0, 255));
  endfunction

  // One frame of random pixels, mostly well formed, with occasional noise.
  task automatic random_frame(input int unsigned w, input int unsigned rows,
                              input int unsigned pads);
    logic sof, pad;
    for (int unsigned rw = 0; rw < rows + pads; rw++)
      for (int unsigned cl = 0; cl < w; cl++) begin
        sof = (rw == 0 && cl == 0) || ($urandom_range(0, 99) < 2);
        pad = (rw >= rows) || ($urandom_range(0, 99) < 3);
        send_pixel(rand_chan(), rand_chan(), rand_chan(), sof, pad);
      end
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    pix_result_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat, magnitude", m_axis_tdata[10:0], -1);
      end else begin
        e = expected_q.pop_front();
        if (m_axis_tdata[10:0] !== e.mag)
          report_mismatch("magnitude", m_axis_tdata[10:0], e.mag);
        if (m_axis_tdata[18:11] !== e.edge_v)
          report_mismatch("edge_value", m_axis_tdata[18:11], e.edge_v);
        if (m_axis_tdata[27:19] !== e.ang)
          report_mismatch("angle", $signed(m_axis_tdata[27:19]), e.ang);
        if (m_axis_tlast !== e.last)
          report_mismatch("last_in_row", m_axis_tlast, e.last);
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk_i) m_axis_tready <= ($urandom_range(0, 99) >= rcv_pct);

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int unsigned w, wr;
    int ph;
    int phase_end;
    build_trig_tables();
    thr_q = 0;
    width_q = WIDTH_RESET;
    for (int i = 0; i < 1024; i++) begin
      upper_q[i] = '0;
      middle_q[i] = '0;
      mid_known[i] = 1'b0;
    end
    for (int i = 0; i < 9; i++) tap[i] = '0;
    col_q = 0;
    row_q = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: one-pixel rows of black and white, then a three-wide frame.
    stim_tab.push_back(cfg_row(CFG_EDGE_THRESHOLD, 11'd0));
    stim_tab.push_back(cfg_row(CFG_IMAGE_WIDTH, 11'd0));
    stim_tab.push_back(pix_row(0, 0, 0, 1, 0, 0, 0, 0, 0));
    stim_tab.push_back(pix_row(255, 255, 255, 0, 0, 1, 1020, 255, 90));
    stim_tab.push_back(pix_row(0, 0, 0, 0, 0, 1, 0, 0, 90));
    stim_tab.push_back(pix_row(9, 9, 9, 0, 1, 1, 1020, 255, 90));
    stim_tab.push_back(cfg_row(CFG_EDGE_THRESHOLD, 11'd1443));
    stim_tab.push_back(cfg_row(CFG_IMAGE_WIDTH, 11'd3));
    stim_tab.push_back(pix_row(255, 0, 0, 1, 0, 0, 0, 0, 0));
    stim_tab.push_back(pix_row(0, 255, 0, 0, 0, 0, 0, 0, 0));
    stim_tab.push_back(pix_row(0, 0, 255, 0, 0, 0, 0, 0, 0));
    stim_tab.push_back(pix_row(255, 255, 255, 0, 0, 0, 0, 0, 0));
    stim_tab.push_back(pix_row(0, 0, 0, 0, 0, 0, 0, 0, 0));
    stim_tab.push_back(pix_row(255, 255, 255, 0, 0, 0, 0, 0, 0));
    stim_tab.push_back(pix_row(17, 200, 90, 0, 0, 0, 0, 0, 0));
    stim_tab.push_back(pix_row(0, 0, 0, 0, 1, 0, 0, 0, 0));
    stim_tab.push_back(pix_row(80, 10, 255, 0, 0, 0, 0, 0, 0));
    stim_tab.push_back(pix_row(0, 0, 0, 0, 1, 0, 0, 0, 0));
    stim_tab.push_back(pix_row(0, 0, 0, 0, 1, 0, 0, 0, 0));
    stim_tab.push_back(pix_row(0, 0, 0, 0, 1, 0, 0, 0, 0));
    stim_tab.push_back(pix_row(0, 0, 0, 0, 1, 0, 0, 0, 0));
    // Start of frame together with pad, then a pad inside row 0.
    stim_tab.push_back(pix_row(0, 0, 0, 1, 1, 0, 0, 0, 0));
    stim_tab.push_back(pix_row(0, 0, 0, 0, 1, 0, 0, 0, 0));
    foreach (stim_tab[i]) begin
      if (stim_tab[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(stim_tab[i].idx, stim_tab[i].data);
      end else begin
        send_pixel(stim_tab[i].r, stim_tab[i].g, stim_tab[i].b,
                   stim_tab[i].sof, stim_tab[i].pad);
        if (stim_tab[i].typed) begin
          void'(expected_q.pop_back());
          expected_q.push_back(stim_tab[i].res);
        end
      end
    end

    // Random phases, cycling through the idling modes and register settings.
    items = 0;
    ph = 0;
    while (items < 1400) begin
      wait_drained();
      case (ph % 4)
        0: begin snd_pct = 0;  rcv_pct = 0;  end
        1: begin snd_pct = 84; rcv_pct = 0;  end
        2: begin snd_pct = 0;  rcv_pct = 84; end
        default: begin snd_pct = 21; rcv_pct = 21; end
      endcase
      case (ph % 3)
        0: write_reg(CFG_EDGE_THRESHOLD, 11'd0);
        1: write_reg(CFG_EDGE_THRESHOLD, 11'($urandom_range(0, 400)));
        default: write_reg(CFG_EDGE_THRESHOLD, ($urandom_range(0, 1)) ? 11'd1443
                                               : 11'($urandom_range(0, 1443)));
      endcase
      if (ph == 5) wr = 2047;
      else if (ph % 7 == 3) wr = 0;
      else if (ph % 7 == 6) wr = 1024 - $urandom_range(0, 1) * 1000;
      else wr = $urandom_range(1, 12);
      write_reg(CFG_IMAGE_WIDTH, 11'(wr));
      w = (wr == 0) ? 1 : ((wr > 1024) ? 1024 : wr);
      if (w >= 1000) begin
        // A long first row ends only at the clamped width; a narrow row and
        // a pad row follow after the width shrinks.
        random_frame(w, 1, 0);
        wait_drained();
        write_reg(CFG_IMAGE_WIDTH, 11'd3);
        for (int i = 0; i < 6; i++)
          send_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b0, i >= 3);
      end else begin
        phase_end = items + 80;
        while (items < phase_end)
          random_frame(w, $urandom_range(1, 5), $urandom_range(0, 2));
      end
      ph++;
    end

    wait_drained();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
